FILE: rtl/pth_sensor_compensation_defines.svh
// Assertion macros shared by the sensor compensation modules.
`ifndef PTH_SENSOR_COMPENSATION_DEFINES_SVH
`define PTH_SENSOR_COMPENSATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTHC_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTHC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/pthc_pkg.sv
// Package with types and constants of the sensor compensation block.
`timescale 1ns / 1ps
package pthc_pkg;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);
	localparam int DivBits = 64;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam logic signed [31:0] HumMax = 32'sd419430400;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TEMP  = 3'd0,
		CFG_PLOW  = 3'd1,
		CFG_PHIGH = 3'd2,
		CFG_PLAST = 3'd3,
		CFG_HUMA  = 3'd4,
		CFG_HUMB  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [47:0] temp_cal;
		logic [63:0] press_cal_low;
		logic [63:0] press_cal_high;
		logic [15:0] press_cal_last;
		logic [31:0] hum_cal_a;
		logic [31:0] hum_cal_b;
	} cal_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} sample_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic    valid;
		sample_t item;
	} head_t;

	// Finished fields carried along the divider.
	typedef struct packed {
		logic signed [31:0] temp;
		logic [16:0]        hum;
		logic               inv;
	} carry_t;
endpackage

FILE: rtl/pthc_if.sv
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps
interface pthc_in_if import pthc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [19:0] raw_pressure;
	logic [19:0] raw_temperature;
	logic [15:0] raw_humidity;
	modport source(output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
	modport sink(input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface pthc_out_if import pthc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic [31:0]        pressure_q8;
	logic [16:0]        humidity_q10;
	logic               pressure_invalid;
	modport source(output valid, temperature_centi, pressure_q8, humidity_q10,
		pressure_invalid, input ready);
	modport sink(input valid, temperature_centi, pressure_q8, humidity_q10,
		pressure_invalid, output ready);
endinterface

interface pthc_cfg_if import pthc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/pth_sensor_compensation.sv
// Top level of the pressure, temperature and humidity compensation block.
`timescale 1ns / 1ps
// Compensates one raw sample set per item with the standard integer formulas:
// temperature in 0.01 degC, pressure in Pa as Q24.8 (flagged and zero when the
// pressure divisor is zero) and humidity as Q7.10 clamped to 100 %RH. Items
// are taken into a four-entry queue and the datapath accepts one item every
// clock while the output is not stalled, so sustained throughput is then one
// item per cycle. Between input and result lie 13 arithmetic stages, the
// 64-stage restoring divider of the pressure path, which sets the depth, and
// the result register. A stalled output holds the whole datapath. The user
// must write calibration registers through the configuration channel only
// while no item is in flight; the block itself does not enforce this.
module pth_sensor_compensation import pthc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pthc_cfg_if.sink  cfg,
	pthc_in_if.sink   inp,
	pthc_out_if.source outp
);
	cal_t  cal;
	head_t head;
	logic  pop;

	pthc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cal    (cal)
	);

	pthc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.inp    (inp),
		.pop    (pop),
		.head   (head)
	);

	pthc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cal    (cal),
		.head   (head),
		.pop    (pop),
		.outp   (outp)
	);
endmodule

FILE: rtl/pthc_regs.sv
// Calibration register file written through the configuration channel.
`timescale 1ns / 1ps
module pthc_regs import pthc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pthc_cfg_if.sink cfg,
	output cal_t   cal
);
	cal_t cal_q;

	assign cfg.ready = 1'b1;
	assign cal = cal_q;

	// Each write lands in the addressed register; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TEMP:  cal_q.temp_cal <= cfg.data[47:0];
				CFG_PLOW:  cal_q.press_cal_low <= cfg.data;
				CFG_PHIGH: cal_q.press_cal_high <= cfg.data;
				CFG_PLAST: cal_q.press_cal_last <= cfg.data[15:0];
				CFG_HUMA:  cal_q.hum_cal_a <= cfg.data[31:0];
				CFG_HUMB:  cal_q.hum_cal_b <= cfg.data[31:0];
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/pthc_front.sv
// Front end: accepts sample items into a short queue ahead of the datapath.
`timescale 1ns / 1ps
`include "pth_sensor_compensation_defines.svh"
module pthc_front import pthc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	pthc_in_if.sink inp,
	input  logic  pop,
	output head_t head
);
	sample_t                mem_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q;
	logic [QueuePtrW-1:0]   rd_ptr_q;
	logic [QueuePtrW:0]     cnt_q;
	logic                   push;
	logic                   take;

	assign inp.ready = (cnt_q != (QueuePtrW+1)'(QueueDepth));
	assign push = inp.valid && inp.ready;
	assign take = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.item = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{raw_pressure: inp.raw_pressure,
				raw_temperature: inp.raw_temperature, raw_humidity: inp.raw_humidity};
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(take);
		end
	end

	`PTHC_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= (QueuePtrW+1)'(QueueDepth))
	`PTHC_ASSERT_NEXT(a_cnt_track, clk, arst_n, push && !take, cnt_q == $past(cnt_q) + 1'b1)
endmodule

FILE: rtl/pthc_back.sv
// Back end: pipelined compensation datapath with divider and result register.
`timescale 1ns / 1ps
`include "pth_sensor_compensation_defines.svh"
module pthc_back import pthc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cal_t   cal,
	input  head_t  head,
	output logic   pop,
	pthc_out_if.source outp
);
	// Calibration fields.
	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
	logic [7:0]         h1, h3;
	logic signed [15:0] h2;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = cal.temp_cal[15:0];
	assign t2 = cal.temp_cal[31:16];
	assign t3 = cal.temp_cal[47:32];
	assign p1 = cal.press_cal_low[15:0];
	assign p2 = cal.press_cal_low[31:16];
	assign p3 = cal.press_cal_low[47:32];
	assign p4 = cal.press_cal_low[63:48];
	assign p5 = cal.press_cal_high[15:0];
	assign p6 = cal.press_cal_high[31:16];
	assign p7 = cal.press_cal_high[47:32];
	assign p8 = cal.press_cal_high[63:48];
	assign p9 = cal.press_cal_last;
	assign h1 = cal.hum_cal_a[7:0];
	assign h2 = cal.hum_cal_a[23:8];
	assign h3 = cal.hum_cal_a[31:24];
	assign h4 = cal.hum_cal_b[11:0];
	assign h5 = cal.hum_cal_b[23:12];
	assign h6 = cal.hum_cal_b[31:24];

	// The whole pipeline advances together when the result register can move.
	logic en;
	logic out_vld_q;
	assign en = !out_vld_q || outp.ready;
	assign pop = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13;
	logic dv_vld [DivBits];

	// Stage 1: offsets of the raw temperature.
	logic signed [17:0] ta_s1, td_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic [15:0]        rh_s1, rh_s2, rh_s3, rh_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1 <= $signed({1'b0, head.item.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
			td_s1 <= $signed({2'b0, head.item.raw_temperature[19:4]}) - $signed({2'b0, t1});
			rp_s1 <= head.item.raw_pressure;
			rh_s1 <= head.item.raw_humidity;
		end
	end

	// Stage 2: first temperature products.
	logic signed [33:0] tam;
	logic signed [35:0] tdm;
	logic signed [31:0] ta_s2, tdd_s2;
	assign tam = ta_s1 * t2;
	assign tdm = td_s1 * td_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2 <= $signed(tam[31:0]) >>> 11;
			tdd_s2 <= $signed(tdm[31:0]) >>> 12;
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;
		end
	end

	// Stage 3: fine temperature.
	logic signed [47:0] tbm;
	logic signed [31:0] tf_s3;
	assign tbm = tdd_s2 * t3;
	always_ff @(posedge clk) begin
		if (en) begin
			tf_s3 <= ta_s2 + ($signed(tbm[31:0]) >>> 14);
			rp_s3 <= rp_s2;
			rh_s3 <= rh_s2;
		end
	end

	// Stage 4: temperature result and offsets for pressure and humidity.
	logic signed [31:0] t5;
	logic signed [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic signed [32:0] pa_s4;
	logic signed [31:0] hx_s4;
	assign t5 = tf_s3 * 32'sd5 + 32'sd128;
	always_ff @(posedge clk) begin
		if (en) begin
			temp_s4 <= t5 >>> 8;
			pa_s4 <= $signed({tf_s3[31], tf_s3}) - 33'sd128000;
			hx_s4 <= tf_s3 - 32'sd76800;
			rp_s4 <= rp_s3;
			rh_s4 <= rh_s3;
		end
	end

	// Stage 5: pressure square and linear terms, humidity first terms.
	logic signed [65:0] aam;
	logic signed [63:0] aa_s5;
	logic signed [48:0] ap5_s5, ap2_s5, ap5_s6, ap2_s6;
	logic signed [43:0] h5x;
	logic signed [39:0] hbm;
	logic signed [40:0] hcm;
	logic [31:0]        hpre_s5;
	logic signed [31:0] hb_s5, hc_s5;
	assign aam = pa_s4 * pa_s4;
	assign h5x = h5 * hx_s4;
	assign hbm = hx_s4 * h6;
	assign hcm = hx_s4 * $signed({1'b0, h3});
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s5 <= aam[63:0];
			ap5_s5 <= pa_s4 * p5;
			ap2_s5 <= pa_s4 * p2;
			hpre_s5 <= {2'b0, rh_s4, 14'b0} - {h4, 20'b0} - h5x[31:0] + 32'd16384;
			hb_s5 <= $signed(hbm[31:0]) >>> 10;
			hc_s5 <= ($signed(hcm[31:0]) >>> 11) + 32'sd32768;
			temp_s5 <= temp_s4;
			rp_s5 <= rp_s4;
		end
	end

	// Stage 6: pressure square products, humidity scale.
	logic signed [79:0] m6f, m3f;
	logic signed [63:0] m6_s6, m3_s6;
	logic signed [63:0] hbc;
	logic signed [31:0] ha_s6, he_s6, ha_s7;
	assign m6f = aa_s5 * p6;
	assign m3f = aa_s5 * p3;
	assign hbc = hb_s5 * hc_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			m6_s6 <= m6f[63:0];
			m3_s6 <= m3f[63:0];
			ap5_s6 <= ap5_s5;
			ap2_s6 <= ap2_s5;
			ha_s6 <= $signed(hpre_s5) >>> 15;
			he_s6 <= ($signed(hbc[31:0]) >>> 10) + 32'sd2097152;
			temp_s6 <= temp_s5;
			rp_s6 <= rp_s5;
		end
	end

	// Stage 7: pressure offset and sensitivity sums, humidity factor.
	logic signed [47:0] hfm;
	logic [31:0]        hfs;
	logic signed [63:0] b1_s7, a1_s7;
	logic signed [31:0] hf_s7;
	assign hfm = he_s6 * h2;
	assign hfs = hfm[31:0] + 32'd8192;
	always_ff @(posedge clk) begin
		if (en) begin
			b1_s7 <= m6_s6 + (64'(ap5_s6) <<< 17) + (64'(p4) <<< 35);
			a1_s7 <= (m3_s6 >>> 8) + (64'(ap2_s6) <<< 12);
			hf_s7 <= $signed(hfs) >>> 14;
			ha_s7 <= ha_s6;
			temp_s7 <= temp_s6;
			rp_s7 <= rp_s6;
		end
	end

	// Stage 8: pressure divisor and numerator, humidity product.
	logic signed [80:0] a2m;
	logic signed [63:0] a2_s8, a2_s9;
	logic [20:0]        pdiff;
	logic [63:0]        num_s8;
	logic signed [63:0] hax;
	logic signed [31:0] hx_s8, hx_s9;
	assign a2m = $signed(a1_s7 + 64'h0000_8000_0000_0000) * $signed({1'b0, p1});
	assign pdiff = 21'd1048576 - {1'b0, rp_s7};
	assign hax = ha_s7 * hf_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			a2_s8 <= $signed(a2m[63:0]) >>> 33;
			num_s8 <= (64'(pdiff) << 31) - b1_s7;
			hx_s8 <= hax[31:0];
			temp_s8 <= temp_s7;
		end
	end

	// Stage 9: scaled numerator, zero divisor check, humidity correction.
	logic [63:0]        n_s9;
	logic               inv_s9;
	logic signed [31:0] hd;
	logic signed [63:0] hdm;
	logic signed [31:0] hd2_s9;
	assign hd = hx_s8 >>> 15;
	assign hdm = hd * hd;
	always_ff @(posedge clk) begin
		if (en) begin
			n_s9 <= num_s8 * 64'd3125;
			a2_s9 <= a2_s8;
			inv_s9 <= (a2_s8 == '0);
			hd2_s9 <= $signed(hdm[31:0]) >>> 7;
			hx_s9 <= hx_s8;
			temp_s9 <= temp_s8;
		end
	end

	// Stage 10: humidity clamp, divider operands as magnitudes.
	logic signed [40:0] hdh;
	logic signed [31:0] hx2;
	logic [16:0]        hum;
	logic [63:0]        mn_s10, md_s10;
	logic               sgn_s10;
	carry_t             c_s10;
	assign hdh = hd2_s9 * $signed({1'b0, h1});
	assign hx2 = hx_s9 - ($signed(hdh[31:0]) >>> 4);
	always_comb begin
		if (hx2 < 0) begin
			hum = '0;
		end else if (hx2 > HumMax) begin
			hum = HumMax[28:12];
		end else begin
			hum = hx2[28:12];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mn_s10 <= n_s9[63] ? (64'd0 - n_s9) : n_s9;
			md_s10 <= a2_s9[63] ? (64'd0 - a2_s9) : a2_s9;
			sgn_s10 <= n_s9[63] ^ a2_s9[63];
			c_s10 <= '{temp: temp_s9, hum: hum, inv: inv_s9};
		end
	end

	// Restoring divider, one quotient bit per stage.
	logic [63:0] dv_rem [DivBits];
	logic [63:0] dv_n [DivBits];
	logic [63:0] dv_d [DivBits];
	logic [63:0] dv_q [DivBits];
	logic        dv_sgn [DivBits];
	carry_t      dv_c [DivBits];
	for (genvar k = 0; k < DivBits; k++) begin : g_div
		logic [63:0] rem_in, n_in, d_in, q_in;
		logic        sgn_in, vld_in;
		carry_t      c_in;
		logic [64:0] r_sh, r_try;
		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign n_in = mn_s10;
			assign d_in = md_s10;
			assign q_in = '0;
			assign sgn_in = sgn_s10;
			assign c_in = c_s10;
			assign vld_in = vld_s10;
		end else begin : g_next
			assign rem_in = dv_rem[k-1];
			assign n_in = dv_n[k-1];
			assign d_in = dv_d[k-1];
			assign q_in = dv_q[k-1];
			assign sgn_in = dv_sgn[k-1];
			assign c_in = dv_c[k-1];
			assign vld_in = dv_vld[k-1];
		end
		assign r_sh = {rem_in, n_in[63]};
		assign r_try = r_sh - {1'b0, d_in};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[k] <= r_try[64] ? r_sh[63:0] : r_try[63:0];
				dv_q[k] <= {q_in[62:0], !r_try[64]};
				dv_n[k] <= {n_in[62:0], 1'b0};
				dv_d[k] <= d_in;
				dv_sgn[k] <= sgn_in;
				dv_c[k] <= c_in;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k] <= 1'b0;
			end else if (en) begin
				dv_vld[k] <= vld_in;
			end
		end
	end

	// Stage 11: signed quotient.
	logic signed [63:0] pr_s11, pr_s12, pr_s13;
	carry_t             c_s11, c_s12, c_s13;
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s11 <= dv_sgn[DivBits-1] ? (64'sd0 - $signed(dv_q[DivBits-1]))
				: $signed(dv_q[DivBits-1]);
			c_s11 <= dv_c[DivBits-1];
		end
	end

	// Stage 12: quadratic and linear pressure correction products.
	logic signed [63:0] s13v;
	logic signed [79:0] m9f, m8f;
	logic [63:0]        m9_s12, sh_s12;
	logic signed [63:0] e_s12, e_s13;
	assign s13v = pr_s11 >>> 13;
	assign m9f = p9 * s13v;
	assign m8f = p8 * pr_s11;
	always_ff @(posedge clk) begin
		if (en) begin
			m9_s12 <= m9f[63:0];
			sh_s12 <= s13v;
			e_s12 <= $signed(m8f[63:0]) >>> 19;
			pr_s12 <= pr_s11;
			c_s12 <= c_s11;
		end
	end

	// Stage 13: partial products of the 64-bit square term.
	logic [63:0] ll_s13;
	logic [31:0] lh_s13, hl_s13;
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s13 <= m9_s12[31:0] * sh_s12[31:0];
			lh_s13 <= m9_s12[31:0] * sh_s12[63:32];
			hl_s13 <= m9_s12[63:32] * sh_s12[31:0];
			e_s13 <= e_s12;
			pr_s13 <= pr_s12;
			c_s13 <= c_s12;
		end
	end

	// Result register: final pressure sum (zero when the divisor was zero) and the carried fields.
	logic [63:0]        c0;
	logic signed [63:0] psum, pfin;
	logic signed [31:0] temp_q;
	logic [31:0]        press_q;
	logic [16:0]        hum_q;
	logic               inv_q;
	assign c0 = ll_s13 + {lh_s13 + hl_s13, 32'b0};
	assign psum = pr_s13 + ($signed(c0) >>> 25) + e_s13;
	assign pfin = (psum >>> 8) + (64'(p7) <<< 4);
	always_ff @(posedge clk) begin
		if (en) begin
			temp_q <= c_s13.temp;
			press_q <= c_s13.inv ? 32'd0 : pfin[31:0];
			hum_q <= c_s13.hum;
			inv_q <= c_s13.inv;
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			vld_s13 <= 1'b0; out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= head.valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2; vld_s4 <= vld_s3;
			vld_s5 <= vld_s4; vld_s6 <= vld_s5; vld_s7 <= vld_s6; vld_s8 <= vld_s7;
			vld_s9 <= vld_s8; vld_s10 <= vld_s9; vld_s11 <= dv_vld[DivBits-1];
			vld_s12 <= vld_s11; vld_s13 <= vld_s12; out_vld_q <= vld_s13;
		end
	end

	assign outp.valid = out_vld_q;
	assign outp.temperature_centi = temp_q;
	assign outp.pressure_q8 = press_q;
	assign outp.humidity_q10 = hum_q;
	assign outp.pressure_invalid = inv_q;

	`PTHC_ASSERT_NOW(a_inv_zero, clk, arst_n, out_vld_q && inv_q, press_q == '0)
	`PTHC_ASSERT_NOW(a_hum_range, clk, arst_n, out_vld_q, hum_q <= 17'd102400)
endmodule

FILE: test/pth_sensor_compensation_tb.sv
// Self-checking testbench for the pressure, temperature and humidity compensation block.
`timescale 1ns / 1ps
module pth_sensor_compensation_tb;
	import pthc_pkg::*;

	localparam time ClkPeriod = 12ns;
	// More than the number of pipeline stages of the block.
	localparam int SettleCycles = 120;
	localparam int HoldCycles = 300;
	localparam logic [CfgIdxW-1:0] CfgUnusedA = 3'd6;
	localparam logic [CfgIdxW-1:0] CfgUnusedB = 3'd7;

	// Datasheet example calibration, packed as the registers hold it.
	localparam logic [47:0] TypTemp = 48'hFC18_6743_6B70;
	localparam logic [63:0] TypPLow = 64'h0B27_0BD0_D643_8E7D;
	localparam logic [63:0] TypPHigh = 64'hC6F8_3C8C_FFF9_008C;
	localparam logic [15:0] TypPLast = 16'h1770;
	localparam logic [31:0] TypHumA = 32'h0001_6A4B;
	localparam logic [31:0] TypHumB = 32'h1E03_2139;

	typedef struct packed {
		logic signed [31:0] temp;
		logic [31:0]        press;
		logic [16:0]        hum;
		logic               inv;
	} reading_t;

	logic clk;
	logic arst_n;

	pthc_cfg_if cfg();
	pthc_in_if inp();
	pthc_out_if outp();

	pth_sensor_compensation u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.inp(inp.sink),
		.outp(outp.source)
	);

	cal_t cal_shadow;
	reading_t expected_readings[$];
	int mismatches = 0;
	bit no_idle = 0;
	bit hold_request = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	// Sign-extend the low 32 bits, as every 32-bit stage wraps.
	function automatic longint w32(longint v);
		return longint'($signed(v[31:0]));
	endfunction

	// Signed division truncating toward zero; the most negative dividend over -1 wraps.
	function automatic longint div_trunc(longint num, longint den);
		if (den == -1)
			return -num;
		return num / den;
	endfunction

	// Integer compensation of one raw sample set with the given calibration.
	function automatic reading_t compensate(cal_t c, sample_t s);
		longint ap, at, ah;
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint h1, h2, h3, h4, h5, h6;
		longint a, b, d, e, f, tf, pr, x;
		reading_t r;
		ap = s.raw_pressure;
		at = s.raw_temperature;
		ah = s.raw_humidity;
		t1 = c.temp_cal[15:0];
		t2 = $signed(c.temp_cal[31:16]);
		t3 = $signed(c.temp_cal[47:32]);
		p1 = c.press_cal_low[15:0];
		p2 = $signed(c.press_cal_low[31:16]);
		p3 = $signed(c.press_cal_low[47:32]);
		p4 = $signed(c.press_cal_low[63:48]);
		p5 = $signed(c.press_cal_high[15:0]);
		p6 = $signed(c.press_cal_high[31:16]);
		p7 = $signed(c.press_cal_high[47:32]);
		p8 = $signed(c.press_cal_high[63:48]);
		p9 = $signed(c.press_cal_last);
		h1 = c.hum_cal_a[7:0];
		h2 = $signed(c.hum_cal_a[23:8]);
		h3 = c.hum_cal_a[31:24];
		h4 = $signed(c.hum_cal_b[11:0]);
		h5 = $signed(c.hum_cal_b[23:12]);
		h6 = $signed(c.hum_cal_b[31:24]);

		// Temperature path, 32-bit stages.
		a = w32((at >>> 3) - (t1 <<< 1));
		a = w32(a * t2) >>> 11;
		d = w32((at >>> 4) - t1);
		b = w32((w32(d * d) >>> 12) * t3) >>> 14;
		tf = w32(a + b);
		r.temp = 32'(w32(tf * 5 + 128) >>> 8);

		// Pressure path, 64-bit stages.
		a = tf - 128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		if (a == 0) begin
			pr = 0;
			r.inv = 1'b1;
		end else begin
			pr = 1048576 - ap;
			pr = div_trunc(((pr <<< 31) - b) * 3125, a);
			d = (p9 * (pr >>> 13) * (pr >>> 13)) >>> 25;
			e = (p8 * pr) >>> 19;
			pr = ((pr + d + e) >>> 8) + (p7 <<< 4);
			r.inv = 1'b0;
		end
		r.press = pr[31:0];

		// Humidity path, 32-bit stages, clamped before the last shift.
		x = w32(tf - 76800);
		a = w32((ah <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
		b = w32(x * h6) >>> 10;
		d = w32((w32(x * h3) >>> 11) + 32768);
		e = w32((w32(b * d) >>> 10) + 2097152);
		f = w32(e * h2 + 8192) >>> 14;
		x = w32(a * f);
		d = x >>> 15;
		d = w32(d * d) >>> 7;
		x = w32(x - (w32(d * h1) >>> 4));
		if (x < 0)
			x = 0;
		if (x > longint'(HumMax))
			x = HumMax;
		r.hum = 17'(x >>> 12);
		return r;
	endfunction

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(99);
		if (no_idle || sel < 45)
			return 0;
		if (sel < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Write one register and mirror it in the shadow calibration.
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_TEMP:  cal_shadow.temp_cal = data[47:0];
			CFG_PLOW:  cal_shadow.press_cal_low = data;
			CFG_PHIGH: cal_shadow.press_cal_high = data;
			CFG_PLAST: cal_shadow.press_cal_last = data[15:0];
			CFG_HUMA:  cal_shadow.hum_cal_a = data[31:0];
			CFG_HUMB:  cal_shadow.hum_cal_b = data[31:0];
			default: ;
		endcase
	endtask

	task automatic load_cal(cal_t c);
		write_reg(CFG_TEMP, 64'(c.temp_cal));
		write_reg(CFG_PLOW, c.press_cal_low);
		write_reg(CFG_PHIGH, c.press_cal_high);
		write_reg(CFG_PLAST, 64'(c.press_cal_last));
		write_reg(CFG_HUMA, 64'(c.hum_cal_a));
		write_reg(CFG_HUMB, 64'(c.hum_cal_b));
	endtask

	// Offer one sample after a random gap and record its expected reading on acceptance.
	task automatic send_sample(sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			inp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		inp.valid <= 1'b1;
		inp.raw_pressure <= s.raw_pressure;
		inp.raw_temperature <= s.raw_temperature;
		inp.raw_humidity <= s.raw_humidity;
		do @(posedge clk); while (!inp.ready);
		expected_readings.push_back(compensate(cal_shadow, s));
	endtask

	// Stop offering at once, let every pending reading arrive, then let the pipeline settle.
	task automatic drain();
		inp.valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic sample_t mk_sample(logic [19:0] p, logic [19:0] t, logic [15:0] h);
		sample_t s;
		s.raw_pressure = p;
		s.raw_temperature = t;
		s.raw_humidity = h;
		return s;
	endfunction

	// Plausible readings about half of the time, anything in range otherwise.
	function automatic sample_t random_sample();
		if ($urandom_range(1))
			return mk_sample(20'($urandom), 20'($urandom), 16'($urandom));
		return mk_sample(20'($urandom_range(480000, 300000)),
			20'($urandom_range(560000, 460000)), 16'($urandom_range(45000, 15000)));
	endfunction

	function automatic cal_t typical_cal();
		cal_t c;
		c.temp_cal = TypTemp;
		c.press_cal_low = TypPLow;
		c.press_cal_high = TypPHigh;
		c.press_cal_last = TypPLast;
		c.hum_cal_a = TypHumA;
		c.hum_cal_b = TypHumB;
		return c;
	endfunction

	// Near the typical calibration mostly, fully random words at times.
	function automatic cal_t random_cal();
		cal_t c;
		logic [63:0] m;
		c = typical_cal();
		if ($urandom_range(3) == 0) begin
			c.temp_cal = 48'({$urandom, $urandom});
			c.press_cal_low = {$urandom, $urandom};
			c.press_cal_high = {$urandom, $urandom};
			c.press_cal_last = 16'($urandom);
			c.hum_cal_a = $urandom;
			c.hum_cal_b = $urandom;
		end else begin
			m = {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF;
			c.temp_cal ^= m[47:0];
			c.press_cal_low ^= m;
			c.press_cal_high ^= {m[31:0], m[63:32]};
			c.press_cal_last ^= m[15:0];
			c.hum_cal_a ^= m[31:0] & 32'h0F0F_0F0F;
			c.hum_cal_b ^= m[63:32] & 32'h0F0F_0F0F;
		end
		return c;
	endfunction

	// Reset values leave the pressure divisor at zero.
	task automatic test_reset_cal();
		send_sample(mk_sample(20'd0, 20'd0, 16'd0));
		send_sample(mk_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd30000));
		drain();
	endtask

	// Typical calibration with extreme and typical readings.
	task automatic test_directed_readings();
		load_cal(typical_cal());
		// Writes beyond the register list must change nothing.
		write_reg(CfgUnusedA, '1);
		write_reg(CfgUnusedB, '1);
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd30000));
		send_sample(mk_sample(20'd0, 20'd0, 16'd0));
		send_sample(mk_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
		send_sample(mk_sample(20'd0, 20'hFFFFF, 16'd0));
		send_sample(mk_sample(20'hFFFFF, 20'd0, 16'hFFFF));
		send_sample(mk_sample(20'h55555, 20'hAAAAA, 16'h5555));
		send_sample(mk_sample(20'hAAAAA, 20'h55555, 16'hAAAA));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'hFFFF));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd0));
		drain();
	endtask

	// Extreme calibration words.
	task automatic test_extreme_cal();
		cal_t c;
		c = '1;
		load_cal(c);
		send_sample(mk_sample(20'd0, 20'd0, 16'd0));
		send_sample(mk_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd30000));
		drain();
		c.temp_cal = 48'h8000_8000_FFFF;
		c.press_cal_low = 64'h8000_8000_8000_FFFF;
		c.press_cal_high = 64'h8000_8000_8000_8000;
		c.press_cal_last = 16'h8000;
		c.hum_cal_a = 32'hFF80_00FF;
		c.hum_cal_b = 32'h8080_0800;
		load_cal(c);
		send_sample(mk_sample(20'd0, 20'hFFFFF, 16'hFFFF));
		send_sample(mk_sample(20'hFFFFF, 20'd0, 16'd0));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd30000));
		c.temp_cal = 48'h7FFF_7FFF_0000;
		c.press_cal_low = 64'h7FFF_7FFF_7FFF_0001;
		c.press_cal_high = 64'h7FFF_7FFF_7FFF_7FFF;
		c.press_cal_last = 16'h7FFF;
		c.hum_cal_a = 32'h007F_FF00;
		c.hum_cal_b = 32'h7F7F_F7FF;
		drain();
		load_cal(c);
		send_sample(mk_sample(20'd0, 20'hFFFFF, 16'hFFFF));
		send_sample(mk_sample(20'hFFFFF, 20'd0, 16'd0));
		send_sample(mk_sample(20'd415148, 20'd519888, 16'd30000));
		drain();
	endtask

	// Random readings over several random calibrations.
	task automatic test_random_phases();
		for (int ph = 0; ph < 10; ph++) begin
			load_cal(random_cal());
			no_idle = (ph % 3 == 2);
			for (int i = 0; i < 60; i++)
				send_sample(random_sample());
			drain();
		end
		no_idle = 0;
	endtask

	// The receiver holds off long enough for the pipeline and queue to fill and stall the input.
	task automatic test_backpressure();
		load_cal(typical_cal());
		no_idle = 1;
		hold_request = 1;
		for (int i = 0; i < 120; i++)
			send_sample(random_sample());
		no_idle = 0;
		drain();
	endtask

	// Receiver: checks each reading and drives ready with random stalls.
	initial begin
		reading_t want;
		int hold_left;
		hold_left = 0;
		outp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && outp.valid && outp.ready) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected reading: temperature_centi %0d", outp.temperature_centi);
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					if (outp.temperature_centi !== want.temp) begin
						$error("temperature_centi: expected %0d, got %0d",
							want.temp, outp.temperature_centi);
						mismatches++;
					end
					if (outp.pressure_q8 !== want.press) begin
						$error("pressure_q8: expected %0h, got %0h",
							want.press, outp.pressure_q8);
						mismatches++;
					end
					if (outp.humidity_q10 !== want.hum) begin
						$error("humidity_q10: expected %0d, got %0d",
							want.hum, outp.humidity_q10);
						mismatches++;
					end
					if (outp.pressure_invalid !== want.inv) begin
						$error("pressure_invalid: expected %0b, got %0b",
							want.inv, outp.pressure_invalid);
						mismatches++;
					end
				end
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				outp.ready <= 1'b0;
			end else if (no_idle) begin
				outp.ready <= 1'b1;
			end else begin
				outp.ready <= (pick_gap() == 0);
			end
		end
	end

	// Reset, then the tests in turn.
	initial begin
		cal_shadow = '0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		inp.valid = 1'b0;
		inp.raw_pressure = '0;
		inp.raw_temperature = '0;
		inp.raw_humidity = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SettleCycles) @(posedge clk);
		test_reset_cal();
		test_directed_readings();
		test_extreme_cal();
		test_random_phases();
		test_backpressure();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
